@@ rtl/fra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the allocate decision for the fenced ring allocator.
// No dependencies; used by fenced_ring_allocator_core and its testbench.
package fra_pkg;

    localparam int RETIRE_DEPTH_DEFAULT = 16;
    localparam logic [31:0] RING_SIZE_RESET = 32'd65536;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_WAIT       = 3'd1;
    localparam logic [2:0] STATUS_TOO_LARGE  = 3'd2;
    localparam logic [2:0] STATUS_NO_SPACE   = 3'd3;
    localparam logic [2:0] STATUS_QUEUE_FULL = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_CHECK
    } fra_state_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] request_size;
        logic [31:0] region_offset;
        logic [63:0] release_fence;
        logic [63:0] completed_fence;
    } fra_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] alloc_offset;
        logic [63:0] wait_fence;
    } fra_result_t;

    // One retire queue entry as stored in memory
    typedef struct packed {
        logic [63:0] fence;
        logic [31:0] start;
        logic [31:0] length;
    } fra_entry_t;

    localparam int ENTRY_W = $bits(fra_entry_t);

    typedef struct packed {
        fra_result_t result;
        logic        offset_we;
        logic [31:0] offset_next;
    } fra_decision_t;

    // Bump, wrap below the last retired end, wait on the head, or report no space.
    function automatic fra_decision_t alloc_decide(
        input logic [31:0] write_offset,
        input logic [31:0] ring_size,
        input logic [31:0] len,
        input logic [32:0] freed_end,
        input logic        queue_nonempty,
        input logic [63:0] head_fence
    );
        fra_decision_t d;
        logic [32:0]   bump_end;
        bump_end = {1'b0, write_offset} + {1'b0, len};
        d.result.status       = STATUS_NO_SPACE;
        d.result.alloc_offset = 32'd0;
        d.result.wait_fence   = 64'd0;
        d.offset_we           = 1'b0;
        d.offset_next         = write_offset;
        if (bump_end <= {1'b0, ring_size}) begin
            d.result.status       = STATUS_OK;
            d.result.alloc_offset = write_offset;
            d.offset_we           = 1'b1;
            d.offset_next         = bump_end[31:0];
        end else if ({1'b0, len} <= freed_end) begin
            d.result.status = STATUS_OK;
            d.offset_we     = 1'b1;
            d.offset_next   = len;
        end else if (queue_nonempty) begin
            d.result.status     = STATUS_WAIT;
            d.result.wait_fence = head_fence;
        end
        return d;
    endfunction

endpackage

@@ rtl/fra_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fra_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fenced_ring_allocator_core.sv @@
`timescale 1ns / 1ps
// Top level of the fenced ring allocator: control, offset and retire queue pointers.
// Depends on fra_pkg and fra_ram (retire queue storage).

// A transaction is taken when start is high and busy is low. A free, and an
// allocate that is too large or finds the retire queue empty, never raises
// busy. Any other allocate walks the retire queue head through the queue memory,
// which has registered read data, one entry per cycle: it holds busy while it
// retires each completed entry and checks an incomplete head. The result appears
// on result for one cycle with result_valid high, the cycle after the decision;
// it cannot be held off, so it must be captured then. The user must write ring_size
// through cfg_we/cfg_data only while the block is idle; it does not enforce this.
module fenced_ring_allocator_core #(
    parameter int RETIRE_DEPTH = fra_pkg::RETIRE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fra_pkg::fra_cmd_t   cmd,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data,
    output logic                result_valid,
    output fra_pkg::fra_result_t result
);

    import fra_pkg::*;

    localparam int PTR_W = $clog2(RETIRE_DEPTH);
    localparam int CNT_W = $clog2(RETIRE_DEPTH + 1);

    fra_state_t       state_reg, state_next;
    logic [31:0]      ring_size_reg;
    logic [31:0]      write_offset_reg, write_offset_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      len_reg, len_next;
    logic [63:0]      done_reg, done_next;
    logic [32:0]      freed_end_reg, freed_end_next;
    fra_result_t      result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             ram_we, ram_re;
    logic [PTR_W-1:0] ram_raddr;
    fra_entry_t       ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    logic             accept;
    logic             head_done;
    logic [32:0]      head_end;
    logic [PTR_W-1:0] head_adv;
    logic [PTR_W-1:0] tail_adv;
    fra_decision_t    dec_idle, dec_pop, dec_stop;

    fra_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(RETIRE_DEPTH)
    ) u_queue_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata = fra_entry_t'(ram_rdata_raw);

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign head_done = (ram_rdata.fence <= done_reg);
    assign head_end  = {1'b0, ram_rdata.start} + {1'b0, ram_rdata.length};
    assign head_adv  = (head_reg == PTR_W'(RETIRE_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_adv  = (tail_reg == PTR_W'(RETIRE_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    assign dec_idle = alloc_decide(write_offset_reg, ring_size_reg, cmd.request_size,
                                   33'd0, 1'b0, 64'd0);
    assign dec_pop  = alloc_decide(write_offset_reg, ring_size_reg, len_reg,
                                   head_end, 1'b0, 64'd0);
    assign dec_stop = alloc_decide(write_offset_reg, ring_size_reg, len_reg,
                                   freed_end_reg, 1'b1, ram_rdata.fence);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd.operation == OP_ALLOC) &&
                    (cmd.request_size <= ring_size_reg) && (count_reg != '0))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!(head_done && (count_reg > CNT_W'(1))))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        write_offset_next = write_offset_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        len_next          = len_reg;
        done_next         = done_reg;
        freed_end_next    = freed_end_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        ram_raddr         = head_reg;
        ram_wdata.fence   = cmd.release_fence;
        ram_wdata.start   = cmd.region_offset;
        ram_wdata.length  = cmd.request_size;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    result_valid_next        = 1'b1;
                    result_next.status       = STATUS_OK;
                    result_next.alloc_offset = 32'd0;
                    result_next.wait_fence   = 64'd0;
                    if (cmd.operation == OP_FREE)
                    begin
                        if (count_reg == CNT_W'(RETIRE_DEPTH))
                        begin
                            result_next.status = STATUS_QUEUE_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            tail_next  = tail_adv;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (cmd.request_size > ring_size_reg)
                    begin
                        result_next.status = STATUS_TOO_LARGE;
                    end
                    else if (count_reg != '0)
                    begin
                        // Fetch the head and hold the result until the walk ends
                        result_valid_next = 1'b0;
                        ram_re            = 1'b1;
                        len_next          = cmd.request_size;
                        done_next         = cmd.completed_fence;
                        freed_end_next    = 33'd0;
                    end
                    else
                    begin
                        result_next = dec_idle.result;
                        if (dec_idle.offset_we)
                        begin
                            write_offset_next = dec_idle.offset_next;
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (head_done)
                begin
                    head_next  = head_adv;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg > CNT_W'(1))
                    begin
                        // Advance to the next head
                        ram_re         = 1'b1;
                        ram_raddr      = head_adv;
                        freed_end_next = head_end;
                    end
                    else
                    begin
                        result_valid_next = 1'b1;
                        result_next       = dec_pop.result;
                        if (dec_pop.offset_we)
                        begin
                            write_offset_next = dec_pop.offset_next;
                        end
                    end
                end
                else
                begin
                    result_valid_next = 1'b1;
                    result_next       = dec_stop.result;
                    if (dec_stop.offset_we)
                    begin
                        write_offset_next = dec_stop.offset_next;
                    end
                end
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            ring_size_reg    <= RING_SIZE_RESET;
            write_offset_reg <= 32'd0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            write_offset_reg <= write_offset_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                ring_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        done_reg      <= done_next;
        freed_end_reg <= freed_end_next;
        result_reg    <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ tb/fenced_ring_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for fenced_ring_allocator_core: directed and random commands,
// each result checked against an in-bench allocator predictor. Depends on fra_pkg.
module fenced_ring_allocator_core_tb;

    import fra_pkg::*;

    localparam int DEPTH        = RETIRE_DEPTH_DEFAULT;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 310;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        start    = 1'b0;
    logic        busy;
    fra_cmd_t    cmd      = '0;
    logic        cfg_we   = 1'b0;
    logic [31:0] cfg_data = '0;
    logic        result_valid;
    fra_result_t result;

    // Predictor state
    logic [31:0] model_ring_size = RING_SIZE_RESET;
    logic [31:0] model_wr_offset = '0;
    logic [63:0] retire_fence  [DEPTH];
    logic [31:0] retire_start  [DEPTH];
    logic [31:0] retire_length [DEPTH];
    int          retire_head  = 0;
    int          retire_tail  = 0;
    int          retire_count = 0;

    fra_result_t expected_results [$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;

    fenced_ring_allocator_core #(.RETIRE_DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Compute the allocator response to one command and update the predictor state
    task automatic predict_allocator(input fra_cmd_t c, output fra_result_t r);
        logic [32:0] freed_end;
        logic [32:0] bump_end;
        r = '0;
        if (c.operation == OP_FREE)
        begin
            if (retire_count >= DEPTH)
            begin
                r.status = STATUS_QUEUE_FULL;
            end
            else
            begin
                retire_fence[retire_tail]  = c.release_fence;
                retire_start[retire_tail]  = c.region_offset;
                retire_length[retire_tail] = c.request_size;
                retire_tail  = (retire_tail == DEPTH - 1) ? 0 : retire_tail + 1;
                retire_count = retire_count + 1;
                r.status = STATUS_OK;
            end
        end
        else if (c.request_size > model_ring_size)
        begin
            r.status = STATUS_TOO_LARGE;
        end
        else
        begin
            freed_end = '0;
            while (retire_count > 0 && retire_fence[retire_head] <= c.completed_fence)
            begin
                freed_end = {1'b0, retire_start[retire_head]}
                          + {1'b0, retire_length[retire_head]};
                retire_head  = (retire_head == DEPTH - 1) ? 0 : retire_head + 1;
                retire_count = retire_count - 1;
            end
            bump_end = {1'b0, model_wr_offset} + {1'b0, c.request_size};
            if (bump_end <= {1'b0, model_ring_size})
            begin
                r.status        = STATUS_OK;
                r.alloc_offset  = model_wr_offset;
                model_wr_offset = bump_end[31:0];
            end
            else if ({1'b0, c.request_size} <= freed_end)
            begin
                r.status        = STATUS_OK;
                model_wr_offset = c.request_size;
            end
            else if (retire_count > 0)
            begin
                r.status     = STATUS_WAIT;
                r.wait_fence = retire_fence[retire_head];
            end
            else
            begin
                r.status = STATUS_NO_SPACE;
            end
        end
    endtask

    task automatic log_mismatch(input string what, input fra_result_t want,
                                input fra_result_t got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
        begin
            $write("mismatch (%s): expected status %0d offset %h fence %h, ",
                   what, want.status, want.alloc_offset, want.wait_fence);
            $display("got status %0d offset %h fence %h",
                     got.status, got.alloc_offset, got.wait_fence);
        end
    endtask

    // Predict on every accepted transaction, check every result against the oldest prediction
    always @(posedge clk)
    begin
        fra_result_t want;
        logic        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
                model_ring_size = cfg_data;
            if (start && !busy)
            begin
                predict_allocator(cmd, want);
                expected_results.push_back(want);
                moved = 1'b1;
            end
            if (result_valid)
            begin
                moved = 1'b1;
                if (expected_results.size() == 0)
                begin
                    log_mismatch("unexpected result", '0, result);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status
                        || result.alloc_offset !== want.alloc_offset
                        || result.wait_fence !== want.wait_fence)
                        log_mismatch("field", want, result);
                end
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Hold start and the command until the block takes the transaction
    task automatic send_item(input fra_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
    endtask

    // Send, then idle for a random gap; runs of zero gaps come in bursts
    task automatic issue_cmd(input fra_cmd_t c);
        int gap;
        send_item(c);
        if (burst_left > 0)
        begin
            burst_left = burst_left - 1;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue_alloc(input logic [31:0] len, input logic [63:0] done);
        fra_cmd_t c;
        c.operation       = OP_ALLOC;
        c.request_size    = len;
        c.region_offset   = $urandom;
        c.release_fence   = {$urandom, $urandom};
        c.completed_fence = done;
        issue_cmd(c);
    endtask

    task automatic issue_free(input logic [31:0] len, input logic [31:0] off,
                              input logic [63:0] fence);
        fra_cmd_t c;
        c.operation       = OP_FREE;
        c.request_size    = len;
        c.region_offset   = off;
        c.release_fence   = fence;
        c.completed_fence = {$urandom, $urandom};
        issue_cmd(c);
    endtask

    // Drop start, wait out every pending result, then idle for DRAIN_CYCLES more
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_ring_size(input logic [31:0] size);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= size;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic test_bump_and_too_large();
        issue_alloc(32'd0, 64'd0);
        issue_alloc(MAX32, MAX64);
        issue_alloc(32'd65536, 64'd0);
        issue_alloc(32'd1, 64'd0);
    endtask

    task automatic test_fence_wait_and_wrap();
        issue_free(32'd100, 32'd0, 64'd5);
        issue_alloc(32'd50, 64'd4);
        issue_alloc(32'd50, 64'd5);
        // region end above 32 bits
        issue_free(MAX32, MAX32, MAX64);
        issue_alloc(32'd65536, MAX64);
    endtask

    task automatic test_queue_full();
        for (int i = 0; i < DEPTH; i++)
            issue_free(32'h1000 * (i + 1), 32'd0, 64'd200 + i);
        issue_free(32'd1, 32'd2, 64'd0);
        issue_alloc(32'd65536, MAX64);
    endtask

    task automatic test_config_extremes();
        // shrink below the write offset, then zero size wraps
        set_ring_size(32'd1);
        issue_alloc(32'd0, 64'd0);
        issue_alloc(32'd1, 64'd0);
        issue_alloc(32'd2, 64'd0);
        set_ring_size(MAX32);
        issue_alloc(MAX32, 64'd0);
    endtask

    task automatic run_random_phase(input logic [31:0] ring, input logic [63:0] base_fence);
        logic [63:0] next_fence;
        logic [31:0] quarter;
        logic [31:0] len;
        logic [31:0] off;
        fra_cmd_t    c;
        int          pick;
        set_ring_size(ring);
        next_fence = base_fence;
        quarter    = (ring >> 2) | 32'd1;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                c.operation       = 1'($urandom_range(0, 1));
                c.request_size    = $urandom;
                c.region_offset   = $urandom;
                c.release_fence   = {$urandom, $urandom};
                c.completed_fence = {$urandom, $urandom};
                issue_cmd(c);
            end
            else if (pick < 56)
            begin
                case ($urandom_range(0, 9))
                    0: len = 32'd0;
                    1: len = ring - $urandom_range(0, quarter);
                    2: len = (ring == MAX32) ? $urandom : ring + $urandom_range(1, MAX32 - ring);
                    default: len = $urandom_range(0, quarter);
                endcase
                if ($urandom_range(0, 15) == 0)
                    issue_alloc(len, MAX64);
                else
                    issue_alloc(len, next_fence - 64'd1 - $urandom_range(0, 8));
            end
            else
            begin
                off = $urandom_range(0, ring);
                len = $urandom_range(0, ring - off);
                if ($urandom_range(0, 3) == 0)
                    off = ring - len;
                issue_free(len, off, next_fence);
                next_fence = next_fence + 64'd1;
            end
            // hold off now and then until the block has answered everything
            if ($urandom_range(0, 39) == 0)
                wait_idle();
        end
    endtask

    task automatic test_random();
        run_random_phase(32'd4096, 64'd16);
        run_random_phase(32'd1, 64'd16);
        run_random_phase(MAX32, 64'hFFFF_FFFF_FFFF_F000);
        run_random_phase(32'd256, {1'b0, $urandom, 31'd0});
        run_random_phase(RING_SIZE_RESET, 64'h8000_0000_0000_0000);
        run_random_phase($urandom_range(1, 32'h0010_0000), {$urandom, 32'd0});
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bump_and_too_large();
        test_fence_wait_and_wrap();
        test_queue_full();
        test_config_extremes();
        test_random();

        wait_idle();
        if (expected_results.size() != 0)
            mismatches = mismatches + expected_results.size();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
